FILE: design/vna_pkg.sv
`timescale 1ns / 1ps
package vna_pkg;

  localparam int DEF_MAX_QUERIES  = 64;
  localparam int DEF_MAX_DIM      = 1024;
  localparam int DEF_ELEMENT_BITS = 16;

  localparam int NORM_W = 47;
  localparam logic [NORM_W-1:0] NORM_MAX = '1;

  localparam int VL_W   = 11;
  localparam int MB_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = VL_W;

  localparam logic [VL_W-1:0] VL_RESET = VL_W'(128);
  localparam logic [MB_W-1:0] MB_RESET = MB_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BATCH     = 1'b1;

  typedef struct packed {
    logic shift;
    logic insert_en;
  } cell_ctl_t;

endpackage

FILE: design/vna_accum.sv
`timescale 1ns / 1ps
module vna_accum import vna_pkg::*; #(
  parameter int MAX_QUERIES  = DEF_MAX_QUERIES,
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS,
  parameter int IDX_W = $clog2(MAX_QUERIES),
  parameter int VC_W  = $clog2(MAX_QUERIES + 1),
  parameter int LEN_W = $clog2(MAX_DIM + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  logic [ELEMENT_BITS-1:0] element,
  input  logic                    batch_end,
  input  logic [LEN_W-1:0]        eff_len,
  output logic                    ins_valid,
  output logic [NORM_W-1:0]       ins_norm,
  output logic [IDX_W-1:0]        ins_idx,
  output logic                    done_valid,
  output logic [VC_W-1:0]         done_count,
  output logic                    done_overflow
);

  localparam int SQ_W  = 2 * ELEMENT_BITS;
  localparam int SUM_W = NORM_W + 1;

  logic                    s1_valid;
  logic                    s1_end;
  logic [SQ_W-1:0]         s1_sq;
  logic [ELEMENT_BITS-1:0] mag;

  logic [NORM_W-1:0] acc, acc_next;
  logic [LEN_W-1:0]  cnt, cnt_next;
  logic [VC_W-1:0]   vc, vc_next;
  logic              ovf, ovf_next;

  logic [SUM_W-1:0]  sum;
  logic [NORM_W-1:0] acc_sat;
  logic [LEN_W-1:0]  cnt_inc;
  logic              close, room;
  logic [VC_W-1:0]   vc_after;
  logic              ovf_after;

  assign mag = element[ELEMENT_BITS-1] ? (~element + 1'b1) : element;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_valid;
    end
    s1_end <= batch_end;
    s1_sq  <= mag * mag;
  end

  always_comb begin
    sum       = {1'b0, acc} + SUM_W'(s1_sq);
    acc_sat   = (sum > {1'b0, NORM_MAX}) ? NORM_MAX : sum[NORM_W-1:0];
    cnt_inc   = cnt + 1'b1;
    close     = (cnt_inc >= eff_len) || s1_end;
    room      = (32'(vc) < MAX_QUERIES);
    vc_after  = (close && room) ? vc + 1'b1 : vc;
    ovf_after = ovf | (close && !room);

    acc_next = acc;
    cnt_next = cnt;
    vc_next  = vc;
    ovf_next = ovf;
    if (s1_valid) begin
      if (close) begin
        acc_next = '0;
        cnt_next = '0;
      end else begin
        acc_next = acc_sat;
        cnt_next = cnt_inc;
      end
      vc_next  = vc_after;
      ovf_next = ovf_after;
      if (s1_end) begin
        vc_next  = '0;
        ovf_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      vc         <= '0;
      ovf        <= 1'b0;
      ins_valid  <= 1'b0;
      done_valid <= 1'b0;
    end else begin
      acc        <= acc_next;
      cnt        <= cnt_next;
      vc         <= vc_next;
      ovf        <= ovf_next;
      ins_valid  <= s1_valid && close && room;
      done_valid <= s1_valid && s1_end;
    end
    ins_norm      <= acc_sat;
    ins_idx       <= vc[IDX_W-1:0];
    done_count    <= vc_after;
    done_overflow <= ovf_after;
  end

endmodule

FILE: design/vna_cell.sv
`timescale 1ns / 1ps
module vna_cell import vna_pkg::*; #(
  parameter int IDX_W = $clog2(DEF_MAX_QUERIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              in_valid,
  input  logic [NORM_W-1:0] in_norm,
  input  logic [IDX_W-1:0]  in_idx,
  input  logic              right_valid,
  input  logic [NORM_W-1:0] right_norm,
  input  logic [IDX_W-1:0]  right_idx,
  output logic              held_valid,
  output logic [NORM_W-1:0] held_norm,
  output logic [IDX_W-1:0]  held_idx,
  output logic              pass_valid,
  output logic [NORM_W-1:0] pass_norm,
  output logic [IDX_W-1:0]  pass_idx
);

  logic take_in;

  // on equal norms the lower index stays ahead
  assign take_in = !held_valid || (in_norm < held_norm) ||
                   ((in_norm == held_norm) && (in_idx < held_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctl.shift) begin
      held_valid <= right_valid;
      held_norm  <= right_norm;
      held_idx   <= right_idx;
      pass_valid <= 1'b0;
    end else if (ctl.insert_en && in_valid) begin
      pass_valid <= held_valid;
      if (take_in) begin
        held_valid <= 1'b1;
        held_norm  <= in_norm;
        held_idx   <= in_idx;
        pass_norm  <= held_norm;
        pass_idx   <= held_idx;
      end else begin
        pass_norm  <= in_norm;
        pass_idx   <= in_idx;
      end
    end else begin
      pass_valid <= 1'b0;
    end
  end

endmodule

FILE: design/vector_norm_argsort_top.sv
`timescale 1ns / 1ps
// Channel  | Signals                                      | Transaction
// ---------+----------------------------------------------+---------------------------
// input    | start, busy, element, batch_end              | start & !busy
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid & cfg_ready
// result   | result_valid, query_index, last, overflow    | result_valid, one cycle
//
// Elements are taken one per cycle while a batch streams in; each closed vector, up
// to MAX_QUERIES per batch, enters a chain of MAX_QUERIES compare/swap cells that keep
// it sorted on the fly. After batch_end, busy stays high while the chain settles, then
// while n results leave cell 0 (arrival order if n < min_batch), one per cycle.
// Synchronous reset clears control state and the cell valid bits.
// The receiver cannot stall; results are strobed for one cycle each.
module vector_norm_argsort_top import vna_pkg::*; #(
  parameter int MAX_QUERIES  = DEF_MAX_QUERIES,
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS,
  parameter int IDX_W = $clog2(MAX_QUERIES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ELEMENT_BITS-1:0] element,
  input  logic                    batch_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    result_valid,
  output logic [IDX_W-1:0]        query_index,
  output logic                    last,
  output logic                    overflow
);

  localparam int VC_W        = $clog2(MAX_QUERIES + 1);
  localparam int LEN_W       = $clog2(MAX_DIM + 1);
  localparam int FLUSH_CYC   = MAX_QUERIES + 4;
  localparam int WAIT_W      = $clog2(FLUSH_CYC + 1);

  localparam logic [1:0] ST_ACCUM = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]        state;
  logic [WAIT_W-1:0] wait_cnt;
  logic [IDX_W-1:0]  k;
  logic [VC_W-1:0]   n;
  logic              ovf;
  logic [VL_W-1:0]   vector_length;
  logic [MB_W-1:0]   min_batch;
  logic [LEN_W-1:0]  eff_len;
  logic              accept, do_sort, is_last;

  logic              ins_valid, done_valid, done_overflow;
  logic [NORM_W-1:0] ins_norm;
  logic [IDX_W-1:0]  ins_idx;
  logic [VC_W-1:0]   done_count;

  logic              c_valid [0:MAX_QUERIES];
  logic [NORM_W-1:0] c_norm  [0:MAX_QUERIES];
  logic [IDX_W-1:0]  c_idx   [0:MAX_QUERIES];
  logic              p_valid [0:MAX_QUERIES];
  logic [NORM_W-1:0] p_norm  [0:MAX_QUERIES];
  logic [IDX_W-1:0]  p_idx   [0:MAX_QUERIES];
  cell_ctl_t         ctl;

  assign busy      = (state != ST_ACCUM);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (vector_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(vector_length) > MAX_DIM) begin
      eff_len = LEN_W'(MAX_DIM);
    end else begin
      eff_len = LEN_W'(vector_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VL_RESET;
      min_batch     <= MB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VECTOR_LENGTH: vector_length <= cfg_data;
        REG_MIN_BATCH:     min_batch     <= cfg_data[MB_W-1:0];
        default: ;
      endcase
    end
  end

  vna_accum #(
    .MAX_QUERIES (MAX_QUERIES),
    .MAX_DIM     (MAX_DIM),
    .ELEMENT_BITS(ELEMENT_BITS),
    .IDX_W       (IDX_W),
    .VC_W        (VC_W),
    .LEN_W       (LEN_W)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (accept),
    .element      (element),
    .batch_end    (batch_end),
    .eff_len      (eff_len),
    .ins_valid    (ins_valid),
    .ins_norm     (ins_norm),
    .ins_idx      (ins_idx),
    .done_valid   (done_valid),
    .done_count   (done_count),
    .done_overflow(done_overflow)
  );

  assign ctl.shift     = (state == ST_EMIT);
  assign ctl.insert_en = 1'b1;

  assign p_valid[0] = ins_valid;
  assign p_norm[0]  = ins_norm;
  assign p_idx[0]   = ins_idx;
  assign c_valid[MAX_QUERIES] = 1'b0;
  assign c_norm[MAX_QUERIES]  = '0;
  assign c_idx[MAX_QUERIES]   = '0;

  for (genvar i = 0; i < MAX_QUERIES; i++) begin : g_cell
    vna_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_valid   (p_valid[i]),
      .in_norm    (p_norm[i]),
      .in_idx     (p_idx[i]),
      .right_valid(c_valid[i+1]),
      .right_norm (c_norm[i+1]),
      .right_idx  (c_idx[i+1]),
      .held_valid (c_valid[i]),
      .held_norm  (c_norm[i]),
      .held_idx   (c_idx[i]),
      .pass_valid (p_valid[i+1]),
      .pass_norm  (p_norm[i+1]),
      .pass_idx   (p_idx[i+1])
    );
  end

  assign do_sort = (32'(n) >= 32'(min_batch));
  assign is_last = ((VC_W'(k) + 1'b1) == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      wait_cnt <= '0;
      k        <= '0;
      n        <= '0;
      ovf      <= 1'b0;
    end else begin
      if (done_valid) begin
        n   <= done_count;
        ovf <= done_overflow;
      end
      unique case (state)
        ST_ACCUM: begin
          if (accept && batch_end) begin
            state    <= ST_FLUSH;
            wait_cnt <= '0;
          end
        end
        ST_FLUSH: begin
          if (32'(wait_cnt) == FLUSH_CYC - 1) begin
            k     <= '0;
            state <= (n == '0) ? ST_ACCUM : ST_EMIT;
          end else begin
            wait_cnt <= wait_cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          k <= k + 1'b1;
          if (is_last) begin
            state <= ST_ACCUM;
          end
        end
        default: state <= ST_ACCUM;
      endcase
    end
  end

  assign result_valid = (state == ST_EMIT);
  assign query_index  = do_sort ? c_idx[0] : k;
  assign last         = is_last;
  assign overflow     = ovf;

endmodule
